// ===== rtl/core/esc_exp_pkg.sv =====
// Package for the escape sequence expander: parse mode codes, character constants, result type.
package esc_exp_pkg;

   // Parse modes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_DEC    = 2'd2;
   localparam logic [1:0] MODE_HEX    = 2'd3;

   // Characters the parser looks for
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_X         = 8'h78;

   // Largest value a decimal escape may produce
   localparam logic [9:0] DEC_MAX = 10'd255;

   // Saturation point of the input position
   localparam logic [15:0] POS_MAX = 16'hffff;

   // Number of entries in the result queue
   localparam int RQ_DEPTH = 4;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       status;
      logic       out_last;
   } result_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } request_type;

endpackage

// ===== rtl/core/esc_exp_if.sv =====
// Channel interfaces for the escape sequence expander: request, result and register write.

interface esc_exp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;

   modport source (output valid, output in_char, output in_last, input ready);
   modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface esc_exp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       has_char;
   logic       status;
   logic       out_last;

   modport source (output valid, output out_char, output has_char, output status,
                   output out_last, input ready);
   modport sink (input valid, input out_char, input has_char, input status,
                 input out_last, output ready);
endinterface

interface esc_exp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink (input valid, input wdata, output ready);
endinterface

// ===== rtl/core/escape_sequence_expander_top.sv =====
// Escape sequence expander: input register, one-pass escape parser, result queue.

// Takes a string one byte per item and expands C-style backslash escapes (named
// escapes, backslash and quotes, up to three decimal digits, x and up to two hex
// digits), giving zero, one or two result items per input byte. The length limit
// register (csr_if.wdata, always ready) truncates the string with status 1 once a
// token starts at a position whose successor reaches the limit; a zero limit ends
// the string at once with status 0. Write it only while the block is idle. Each
// byte passes an input register, then the parser, which writes its results into
// a four-entry result queue. One byte is accepted every cycle while the queue
// has room for two more results; the rsp port drains one result per cycle while
// rsp ready is held, so strings whose bytes expand to two results run at the
// output rate.
module escape_sequence_expander_top (
   input  logic              clock,
   input  logic              reset,
   esc_exp_req_if.sink       req_if,
   esc_exp_rsp_if.source     rsp_if,
   esc_exp_csr_if.sink       csr_if
);

   localparam int QW = $clog2(esc_exp_pkg::RQ_DEPTH);

   // Configuration
   logic [15:0] limit_ff;

   // Input register
   logic                     s_valid_ff, s_valid_in;
   esc_exp_pkg::request_type s_ff;

   // Parser state
   logic [1:0]  mode_ff, mode_in;
   logic [9:0]  dv_ff, dv_in;
   logic [1:0]  dc_ff, dc_in;
   logic [15:0] pos_ff, pos_in;
   logic        stop_ff, stop_in;

   // Parser results for the item in the input register
   esc_exp_pkg::result_type res [2];
   logic [1:0]              n_res;

   // Result queue
   esc_exp_pkg::result_type q_ff [esc_exp_pkg::RQ_DEPTH];
   logic [QW-1:0]           wr_ff, wr_in, rd_ff, rd_in;
   logic [QW:0]             cnt_ff, cnt_in;

   logic req_acc, rsp_pop, fire;

   // Build one result item
   function automatic esc_exp_pkg::result_type mk (
      input logic [7:0] ch, input logic has, input logic st, input logic last);
      esc_exp_pkg::result_type r;
      r.out_char = ch;
      r.has_char = has;
      r.status   = st;
      r.out_last = last;
      return r;
   endfunction

   // Named escape translation; unknown escapes give a backslash
   function automatic logic [7:0] named_escape (input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h61:   r = 8'd7;
         8'h62:   r = 8'd8;
         8'h66:   r = 8'd12;
         8'h6e:   r = 8'd10;
         8'h72:   r = 8'd13;
         8'h74:   r = 8'd9;
         8'h76:   r = 8'd11;
         esc_exp_pkg::CH_BACKSLASH: r = esc_exp_pkg::CH_BACKSLASH;
         esc_exp_pkg::CH_SQUOTE:    r = esc_exp_pkg::CH_SQUOTE;
         esc_exp_pkg::CH_DQUOTE:    r = esc_exp_pkg::CH_DQUOTE;
         default: r = esc_exp_pkg::CH_BACKSLASH;
      endcase
      return r;
   endfunction

   // Hex digit value, bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_val (input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

   // Handshakes
   assign fire      = s_valid_ff && (cnt_ff <= (QW+1)'(esc_exp_pkg::RQ_DEPTH - 2));
   assign req_if.ready = !s_valid_ff || fire;
   assign req_acc   = req_if.valid && req_if.ready;
   assign rsp_if.valid = (cnt_ff != '0);
   assign rsp_pop   = rsp_if.valid && rsp_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.out_char = q_ff[rd_ff].out_char;
   assign rsp_if.has_char = q_ff[rd_ff].has_char;
   assign rsp_if.status   = q_ff[rd_ff].status;
   assign rsp_if.out_last = q_ff[rd_ff].out_last;

   // Escape parser for the registered byte
   always_comb begin
      logic [7:0] c;
      logic [3:0] d;
      logic [7:0] dsub;
      logic [9:0] v;
      logic [4:0] h;
      logic [7:0] hv;
      logic       is_dig;
      logic       do_tok;

      c       = s_ff.in_char;
      dsub    = c - esc_exp_pkg::CH_ZERO;
      d       = dsub[3:0];
      is_dig  = (c inside {[esc_exp_pkg::CH_ZERO:esc_exp_pkg::CH_NINE]});
      v       = (dv_ff * 10'd10) + {6'd0, d};
      h       = hex_val(c);
      hv      = {dv_ff[3:0], h[3:0]};
      do_tok  = 1'b0;

      mode_in = mode_ff;
      dv_in   = dv_ff;
      dc_in   = dc_ff;
      pos_in  = pos_ff;
      stop_in = stop_ff;
      res[0]  = mk(8'd0, 1'b0, 1'b0, 1'b0);
      res[1]  = mk(8'd0, 1'b0, 1'b0, 1'b0);
      n_res   = 2'd0;

      if (!stop_ff) begin
         // Escape state machine
         case (mode_ff)
            esc_exp_pkg::MODE_ESC: begin
               if (is_dig) begin
                  mode_in = esc_exp_pkg::MODE_DEC;
                  dv_in   = {6'd0, d};
                  dc_in   = 2'd1;
               end else if (c == esc_exp_pkg::CH_X) begin
                  mode_in = esc_exp_pkg::MODE_HEX;
                  dv_in   = 10'd0;
                  dc_in   = 2'd0;
               end else begin
                  mode_in = esc_exp_pkg::MODE_NORMAL;
                  res[n_res[0]] = mk(named_escape(c), 1'b1, 1'b0, 1'b0);
                  n_res = n_res + 2'd1;
               end
            end
            esc_exp_pkg::MODE_DEC: begin
               if (is_dig) begin
                  if (dc_ff == 2'd2) begin
                     mode_in = esc_exp_pkg::MODE_NORMAL;
                     dc_in   = 2'd0;
                     dv_in   = 10'd0;
                     if (v > esc_exp_pkg::DEC_MAX) begin
                        // third digit would overflow: it becomes plain text
                        res[n_res[0]] = mk(dv_ff[7:0], 1'b1, 1'b0, 1'b0);
                        n_res  = n_res + 2'd1;
                        do_tok = 1'b1;
                     end else begin
                        res[n_res[0]] = mk(v[7:0], 1'b1, 1'b0, 1'b0);
                        n_res = n_res + 2'd1;
                     end
                  end else begin
                     dv_in = v;
                     dc_in = dc_ff + 2'd1;
                  end
               end else begin
                  mode_in = esc_exp_pkg::MODE_NORMAL;
                  res[n_res[0]] = mk(dv_ff[7:0], 1'b1, 1'b0, 1'b0);
                  n_res  = n_res + 2'd1;
                  dv_in  = 10'd0;
                  dc_in  = 2'd0;
                  do_tok = 1'b1;
               end
            end
            esc_exp_pkg::MODE_HEX: begin
               if (h[4]) begin
                  if (dc_ff == 2'd1) begin
                     mode_in = esc_exp_pkg::MODE_NORMAL;
                     res[n_res[0]] = mk(hv, 1'b1, 1'b0, 1'b0);
                     n_res = n_res + 2'd1;
                     dv_in = 10'd0;
                     dc_in = 2'd0;
                  end else begin
                     dv_in = {2'd0, hv};
                     dc_in = 2'd1;
                  end
               end else begin
                  mode_in = esc_exp_pkg::MODE_NORMAL;
                  res[n_res[0]] = mk(dv_ff[7:0], 1'b1, 1'b0, 1'b0);
                  n_res  = n_res + 2'd1;
                  dv_in  = 10'd0;
                  dc_in  = 2'd0;
                  do_tok = 1'b1;
               end
            end
            default: begin
               mode_in = esc_exp_pkg::MODE_NORMAL;
               do_tok  = 1'b1;
            end
         endcase

         // New token: limit check, then backslash or plain character
         if (do_tok) begin
            if (limit_ff == 16'd0) begin
               stop_in = 1'b1;
               res[n_res[0]] = mk(8'd0, 1'b0, 1'b0, 1'b1);
               n_res = n_res + 2'd1;
            end else if (({1'b0, pos_ff} + 17'd1) >= {1'b0, limit_ff}) begin
               stop_in = 1'b1;
               res[n_res[0]] = mk(8'd0, 1'b0, 1'b1, 1'b1);
               n_res = n_res + 2'd1;
            end else if (c == esc_exp_pkg::CH_BACKSLASH) begin
               mode_in = esc_exp_pkg::MODE_ESC;
            end else begin
               res[n_res[0]] = mk(c, 1'b1, 1'b0, 1'b0);
               n_res = n_res + 2'd1;
            end
         end

         if (pos_ff != esc_exp_pkg::POS_MAX) begin
            pos_in = pos_ff + 16'd1;
         end

         // End of string: flush a pending escape and mark the final result
         if (s_ff.in_last && !stop_in) begin
            if (mode_in == esc_exp_pkg::MODE_ESC) begin
               res[n_res[0]] = mk(esc_exp_pkg::CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
               n_res = n_res + 2'd1;
            end else if (mode_in == esc_exp_pkg::MODE_DEC ||
                         mode_in == esc_exp_pkg::MODE_HEX) begin
               res[n_res[0]] = mk(dv_in[7:0], 1'b1, 1'b0, 1'b0);
               n_res = n_res + 2'd1;
            end
            if (n_res == 2'd0) begin
               res[0] = mk(8'd0, 1'b0, 1'b0, 1'b1);
               n_res  = 2'd1;
            end else begin
               res[~n_res[0]].out_last = 1'b1;
            end
         end
      end

      // Per-string state returns to reset after the final byte
      if (s_ff.in_last) begin
         mode_in = esc_exp_pkg::MODE_NORMAL;
         dv_in   = 10'd0;
         dc_in   = 2'd0;
         pos_in  = 16'd0;
         stop_in = 1'b0;
      end
   end

   // Queue pointer and count update
   always_comb begin
      logic [1:0] n_push;
      n_push = fire ? n_res : 2'd0;
      wr_in  = wr_ff + QW'(n_push);
      rd_in  = rd_ff + QW'(rsp_pop);
      cnt_in = cnt_ff + (QW+1)'(n_push) - (QW+1)'(rsp_pop);
   end

   assign s_valid_in = req_acc ? 1'b1 : (fire ? 1'b0 : s_valid_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= 16'd0;
         s_valid_ff <= 1'b0;
         mode_ff    <= esc_exp_pkg::MODE_NORMAL;
         dv_ff      <= 10'd0;
         dc_ff      <= 2'd0;
         pos_ff     <= 16'd0;
         stop_ff    <= 1'b0;
         wr_ff      <= '0;
         rd_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         if (csr_if.valid) begin
            limit_ff <= csr_if.wdata;
         end
         s_valid_ff <= s_valid_in;
         if (fire) begin
            mode_ff <= mode_in;
            dv_ff   <= dv_in;
            dc_ff   <= dc_in;
            pos_ff  <= pos_in;
            stop_ff <= stop_in;
         end
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers: input byte and queue entries
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s_ff.in_char <= req_if.in_char;
         s_ff.in_last <= req_if.in_last;
      end
      if (fire && n_res != 2'd0) begin
         q_ff[wr_ff] <= res[0];
      end
      if (fire && n_res == 2'd2) begin
         q_ff[wr_ff + QW'(1)] <= res[1];
      end
   end

endmodule

// ===== bench/escape_sequence_expander_top_tb.sv =====
// Testbench for the escape sequence expander: random strings, self-checking predictor.
`timescale 1ns / 100ps

module escape_sequence_expander_top_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;

   // Control codes produced by the named escapes
   localparam logic [7:0] CH_BEL = 8'd7;
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_VT  = 8'd11;
   localparam logic [7:0] CH_FF  = 8'd12;
   localparam logic [7:0] CH_CR  = 8'd13;

   logic clock;
   logic reset;

   esc_exp_req_if req_if ();
   esc_exp_rsp_if rsp_if ();
   esc_exp_csr_if csr_if ();

   escape_sequence_expander_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Raw bytes waiting to be sent, expanded bytes waiting to come back
   esc_exp_pkg::request_type raw_bytes [$];
   esc_exp_pkg::result_type  expanded_bytes [$];

   // Predictor copy of the parser state and the length limit
   logic [15:0] limit_reg;
   logic [1:0]  esc_mode;
   logic [9:0]  num_value;
   logic [1:0]  num_digits;
   logic [15:0] str_pos;
   logic        str_stopped;
   logic        str_truncated;

   // Results of the byte being predicted
   esc_exp_pkg::result_type step_res [2];
   int                      step_n;

   int bad_results;
   int cycle_count;
   int hold_requests;
   int hold_seen;

   // Sender burst state
   int                       burst_left;
   int                       gap_left;
   esc_exp_pkg::request_type next_byte;

   // Receiver stall state
   int stall_mode;
   int window_left;
   int hold_left;
   int pattern_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // At most two results per byte
   function automatic void add_expanded(logic [7:0] ch, logic has, logic st, logic lst);
      if (step_n < 2) begin
         step_res[step_n] = {ch, has, st, lst};
         step_n++;
      end
   endfunction

   // A plain character or an opening backslash; the limit is checked here
   function automatic void begin_token(logic [7:0] c);
      if (limit_reg == 16'd0) begin
         str_stopped = 1'b1;
         add_expanded(8'h00, 1'b0, 1'b0, 1'b1);
      end else if ({1'b0, str_pos} + 17'd1 >= {1'b0, limit_reg}) begin
         str_stopped   = 1'b1;
         str_truncated = 1'b1;
         add_expanded(8'h00, 1'b0, 1'b1, 1'b1);
      end else if (c == esc_exp_pkg::CH_BACKSLASH) begin
         esc_mode = esc_exp_pkg::MODE_ESC;
      end else begin
         add_expanded(c, 1'b1, 1'b0, 1'b0);
      end
   endfunction

   // Expand one accepted byte and queue the results it causes
   function automatic void expand_byte(logic [7:0] c, logic lst);
      logic [9:0] v;
      int         h;
      int         k;
      step_n = 0;
      if (!str_stopped) begin
         case (esc_mode)
            esc_exp_pkg::MODE_ESC: begin
               if (c >= esc_exp_pkg::CH_ZERO && c <= esc_exp_pkg::CH_NINE) begin
                  esc_mode   = esc_exp_pkg::MODE_DEC;
                  num_value  = {2'd0, c - esc_exp_pkg::CH_ZERO};
                  num_digits = 2'd1;
               end else if (c == esc_exp_pkg::CH_X) begin
                  esc_mode   = esc_exp_pkg::MODE_HEX;
                  num_value  = 10'd0;
                  num_digits = 2'd0;
               end else begin
                  esc_mode = esc_exp_pkg::MODE_NORMAL;
                  case (c)
                     "a":                    v = {2'd0, CH_BEL};
                     "b":                    v = {2'd0, CH_BS};
                     "f":                    v = {2'd0, CH_FF};
                     "n":                    v = {2'd0, CH_LF};
                     "r":                    v = {2'd0, CH_CR};
                     "t":                    v = {2'd0, CH_TAB};
                     "v":                    v = {2'd0, CH_VT};
                     esc_exp_pkg::CH_SQUOTE: v = {2'd0, esc_exp_pkg::CH_SQUOTE};
                     esc_exp_pkg::CH_DQUOTE: v = {2'd0, esc_exp_pkg::CH_DQUOTE};
                     // backslash itself, and unknown escapes
                     default:                v = {2'd0, esc_exp_pkg::CH_BACKSLASH};
                  endcase
                  add_expanded(v[7:0], 1'b1, 1'b0, 1'b0);
               end
            end
            esc_exp_pkg::MODE_DEC: begin
               if (c >= esc_exp_pkg::CH_ZERO && c <= esc_exp_pkg::CH_NINE &&
                   num_digits < 2'd3) begin
                  v = 10'(num_value * 10 + (c - esc_exp_pkg::CH_ZERO));
                  if (num_digits + 1 >= 3) begin
                     esc_mode   = esc_exp_pkg::MODE_NORMAL;
                     num_digits = 2'd0;
                     // too large: keep two digits, third one is a new token
                     if (v > esc_exp_pkg::DEC_MAX) begin
                        add_expanded(num_value[7:0], 1'b1, 1'b0, 1'b0);
                        begin_token(c);
                     end else begin
                        add_expanded(v[7:0], 1'b1, 1'b0, 1'b0);
                     end
                     num_value = 10'd0;
                  end else begin
                     num_value = v;
                     num_digits++;
                  end
               end else begin
                  esc_mode = esc_exp_pkg::MODE_NORMAL;
                  add_expanded(num_value[7:0], 1'b1, 1'b0, 1'b0);
                  num_value  = 10'd0;
                  num_digits = 2'd0;
                  begin_token(c);
               end
            end
            esc_exp_pkg::MODE_HEX: begin
               if (c >= esc_exp_pkg::CH_ZERO && c <= esc_exp_pkg::CH_NINE)
                  h = c - esc_exp_pkg::CH_ZERO;
               else if (c >= "a" && c <= "f")
                  h = c - "a" + 10;
               else if (c >= "A" && c <= "F")
                  h = c - "A" + 10;
               else
                  h = -1;
               if (h >= 0 && num_digits < 2'd2) begin
                  num_value = {2'd0, num_value[3:0], h[3:0]};
                  num_digits++;
                  if (num_digits >= 2'd2) begin
                     esc_mode = esc_exp_pkg::MODE_NORMAL;
                     add_expanded(num_value[7:0], 1'b1, 1'b0, 1'b0);
                     num_value  = 10'd0;
                     num_digits = 2'd0;
                  end
               end else begin
                  esc_mode = esc_exp_pkg::MODE_NORMAL;
                  add_expanded(num_value[7:0], 1'b1, 1'b0, 1'b0);
                  num_value  = 10'd0;
                  num_digits = 2'd0;
                  begin_token(c);
               end
            end
            default: begin
               esc_mode = esc_exp_pkg::MODE_NORMAL;
               begin_token(c);
            end
         endcase
         if (str_pos < esc_exp_pkg::POS_MAX)
            str_pos++;

         // End of string: flush a pending escape and mark the final result
         if (lst && !str_stopped) begin
            if (esc_mode == esc_exp_pkg::MODE_ESC)
               add_expanded(esc_exp_pkg::CH_BACKSLASH, 1'b1, 1'b0, 1'b0);
            else if (esc_mode == esc_exp_pkg::MODE_DEC || esc_mode == esc_exp_pkg::MODE_HEX)
               add_expanded(num_value[7:0], 1'b1, 1'b0, 1'b0);
            if (step_n == 0)
               add_expanded(8'h00, 1'b0, 1'b0, 1'b1);
            else
               step_res[step_n - 1].out_last = 1'b1;
         end
      end
      for (k = 0; k < step_n; k++)
         expanded_bytes.push_back(step_res[k]);
      if (lst) begin
         esc_mode      = esc_exp_pkg::MODE_NORMAL;
         num_value     = 10'd0;
         num_digits    = 2'd0;
         str_pos       = 16'd0;
         str_stopped   = 1'b0;
         str_truncated = 1'b0;
      end
   endfunction

   // Sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_if.valid && req_if.ready)
            expand_byte(req_if.in_char, req_if.in_last);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (raw_bytes.size() != 0) begin
               next_byte = raw_bytes.pop_front();
               req_if.valid   <= 1'b1;
               req_if.in_char <= next_byte.in_char;
               req_if.in_last <= next_byte.in_last;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compare each item with the oldest expected result, stall on a pattern
   always @(posedge clock) begin
      esc_exp_pkg::result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode    = 0;
         window_left   = 0;
         hold_left     = 0;
         pattern_count = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expanded_bytes.size() == 0) begin
               $error("unexpected result: out_char %0h has_char %0b status %0b out_last %0b",
                      rsp_if.out_char, rsp_if.has_char, rsp_if.status, rsp_if.out_last);
               bad_results++;
            end else begin
               want = expanded_bytes.pop_front();
               if (rsp_if.out_char !== want.out_char) begin
                  $error("out_char: expected %0h, got %0h", want.out_char, rsp_if.out_char);
                  bad_results++;
               end
               if (rsp_if.has_char !== want.has_char) begin
                  $error("has_char: expected %0b, got %0b", want.has_char, rsp_if.has_char);
                  bad_results++;
               end
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp_if.status);
                  bad_results++;
               end
               if (rsp_if.out_last !== want.out_last) begin
                  $error("out_last: expected %0b, got %0b", want.out_last, rsp_if.out_last);
                  bad_results++;
               end
            end
         end

         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (window_left == 0) begin
            stall_mode  = $urandom_range(0, 3);
            window_left = $urandom_range(20, 80);
         end else begin
            window_left--;
         end
         pattern_count++;

         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 1) == 0);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ((pattern_count % 5) < 3);
            endcase
         end
      end
   end

   task automatic push_raw(input logic [7:0] c, input logic lst);
      esc_exp_pkg::request_type r;
      r.in_char = c;
      r.in_last = lst;
      raw_bytes.push_back(r);
   endtask

   // Wait for all bytes to go out and all results to come back
   task automatic settle();
      while (raw_bytes.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expanded_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.wdata <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      limit_reg = value;
   endtask

   // One string of well-formed escapes, plain text and noise, cut to len bytes
   task automatic queue_string(input int len);
      logic [7:0] s [$];
      int         kind;
      int         nd;
      int         d;
      int         k;
      while (s.size() < len) begin
         kind = $urandom_range(0, 11);
         case (kind)
            0, 1, 2, 3: s.push_back(8'($urandom_range(32, 126)));
            4: s.push_back(8'($urandom_range(0, 255)));
            5, 6: begin
               s.push_back(esc_exp_pkg::CH_BACKSLASH);
               case ($urandom_range(0, 9))
                  0:       s.push_back("a");
                  1:       s.push_back("b");
                  2:       s.push_back("f");
                  3:       s.push_back("n");
                  4:       s.push_back("r");
                  5:       s.push_back("t");
                  6:       s.push_back("v");
                  7:       s.push_back(esc_exp_pkg::CH_BACKSLASH);
                  8:       s.push_back(esc_exp_pkg::CH_SQUOTE);
                  default: s.push_back(esc_exp_pkg::CH_DQUOTE);
               endcase
            end
            7, 8: begin
               s.push_back(esc_exp_pkg::CH_BACKSLASH);
               nd = $urandom_range(1, 3);
               for (k = 0; k < nd; k++)
                  s.push_back(8'(esc_exp_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            9, 10: begin
               s.push_back(esc_exp_pkg::CH_BACKSLASH);
               s.push_back(esc_exp_pkg::CH_X);
               nd = $urandom_range(0, 2);
               for (k = 0; k < nd; k++) begin
                  d = $urandom_range(0, 21);
                  if (d < 10)
                     s.push_back(8'(esc_exp_pkg::CH_ZERO + d));
                  else if (d < 16)
                     s.push_back(8'("a" + d - 10));
                  else
                     s.push_back(8'("A" + d - 16));
               end
            end
            default: begin
               // unknown escape, or anything else after a backslash
               s.push_back(esc_exp_pkg::CH_BACKSLASH);
               s.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      for (k = 0; k < len; k++)
         push_raw(s[k], k == len - 1);
   endtask

   task automatic run_phase(input logic [15:0] limit, input int n_items, input int max_len,
                            input bit with_hold);
      int sent;
      int len;
      write_limit(limit);
      @(negedge clock);
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 7) == 0) ? max_len : $urandom_range(1, max_len);
         queue_string(len);
         sent += len;
      end
      // receiver holds off while the sender keeps offering items
      if (with_hold)
         hold_requests++;
      settle();
   endtask

   // Stimulus
   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.in_char = 8'h00;
      req_if.in_last = 1'b0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.wdata   = 16'h0000;
      limit_reg      = 16'd0;
      esc_mode       = esc_exp_pkg::MODE_NORMAL;
      num_value      = 10'd0;
      num_digits     = 2'd0;
      str_pos        = 16'd0;
      str_stopped    = 1'b0;
      str_truncated  = 1'b0;
      bad_results    = 0;
      cycle_count    = 0;
      hold_requests  = 0;
      hold_seen      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes, named, decimal, hex, unknown, lone backslash at end
      write_limit(16'hffff);
      @(negedge clock);
      push_raw(8'h00, 1'b0);
      push_raw(8'hff, 1'b1);
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b0);
      push_raw("n", 1'b0);
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b0);
      push_raw("t", 1'b0);
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b0);
      push_raw("1", 1'b0);
      push_raw("2", 1'b0);
      push_raw("3", 1'b0);
      // over 255: two digits kept, the third is plain text
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b0);
      push_raw("2", 1'b0);
      push_raw("5", 1'b0);
      push_raw("6", 1'b0);
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b0);
      push_raw(esc_exp_pkg::CH_X, 1'b0);
      push_raw("4", 1'b0);
      push_raw("f", 1'b0);
      // hex with no digit gives zero, then the byte starts a token
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b0);
      push_raw(esc_exp_pkg::CH_X, 1'b0);
      push_raw("g", 1'b0);
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b0);
      push_raw("q", 1'b0);
      push_raw(esc_exp_pkg::CH_BACKSLASH, 1'b1);
      // sender waits here until every result is back
      settle();

      run_phase(16'hffff, 200, 30, 1'b0);
      run_phase(16'd0, 40, 6, 1'b0);
      run_phase(16'd1, 40, 6, 1'b0);
      run_phase(16'd2, 60, 8, 1'b0);
      run_phase(16'($urandom_range(3, 12)), 150, 20, 1'b0);
      run_phase(16'hffff, 200, 40, 1'b1);
      run_phase(16'($urandom_range(13, 64)), 150, 80, 1'b0);

      if (bad_results == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
